/* design/assert_macros.svh */
// assertion macros for the design files, used by miller_rabin_prime_test_core
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a implies b in the same cycle
`define CHK_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("check failed");

// a implies b in the next cycle
`define CHK_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("check failed");

`endif

/* design/mrpt_pkg.sv */
// shared constants and witness table for the miller-rabin core
// no dependencies
package mrpt_pkg;

    localparam int VALUE_WIDTH_DEF = 63;
    localparam int WITNESS_COUNT = 12;
    localparam logic [63:0] SKIP_COMPOSITE = 64'd3215031751;

    typedef struct packed {
        logic busy;
        logic done;
    } mm_stat_t;

    function automatic logic [5:0] witness(input logic [3:0] idx);
        logic [5:0] w;
        begin
            case (idx)
                4'd0: w = 6'd2;
                4'd1: w = 6'd3;
                4'd2: w = 6'd5;
                4'd3: w = 6'd7;
                4'd4: w = 6'd11;
                4'd5: w = 6'd13;
                4'd6: w = 6'd17;
                4'd7: w = 6'd19;
                4'd8: w = 6'd23;
                4'd9: w = 6'd29;
                4'd10: w = 6'd31;
                4'd11: w = 6'd37;
                default: w = 6'd0;
            endcase
            return w;
        end
    endfunction

endpackage

/* design/mrpt_mulmod.sv */
// bit-serial exact modular multiplier, one multiplier bit per cycle
// depends on mrpt_pkg
module mrpt_mulmod
    import mrpt_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] x,
    input  logic [VALUE_WIDTH-1:0] y,
    input  logic [VALUE_WIDTH-1:0] m,
    output logic [VALUE_WIDTH-1:0] r,
    output mm_stat_t               stat
);
    localparam int CW = $clog2(VALUE_WIDTH);

    logic                   run_reg, run_next;
    logic                   done_reg, done_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [VALUE_WIDTH-1:0] x_reg, y_reg, m_reg, r_reg;
    logic [VALUE_WIDTH-1:0] y_next, r_next;
    logic [VALUE_WIDTH:0]   dbl, dbl_red, sum;

    always_comb
    begin
        dbl = {r_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, m_reg}) ? dbl - {1'b0, m_reg} : dbl;
        sum = dbl_red + {1'b0, x_reg};
        if (!y_reg[VALUE_WIDTH-1])
            sum = dbl_red;
        else if (sum >= {1'b0, m_reg})
            sum = sum - {1'b0, m_reg};
        run_next = run_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        y_next = y_reg;
        r_next = r_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = CW'(VALUE_WIDTH - 1);
            r_next = '0;
        end
        else if (run_reg)
        begin
            r_next = sum[VALUE_WIDTH-1:0];
            y_next = {y_reg[VALUE_WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                run_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= x;
            y_reg <= y;
            m_reg <= m;
        end
        else
            y_reg <= y_next;
        r_reg <= r_next;
    end

    assign r = r_reg;
    assign stat.busy = run_reg;
    assign stat.done = done_reg;
endmodule

/* design/miller_rabin_prime_test_core.sv */
// channel | dir | payload                     | handshake
// s_axis  | in  | tdata[VALUE_WIDTH-1:0] = n  | s_tvalid / s_tready
// m_axis  | out | tdata[0] = is_prime         | m_tvalid / m_tready
// one candidate at a time; every modular product runs in the shared bit-serial
// multiplier, and a 63-bit prime is tested against all twelve witness bases;
// inputs below 4 and SKIP_COMPOSITE are decided without the multiplier.
// s_tready is high only while idle; a result waits in the output register until taken.
// asynchronous active-low reset returns the sequencer to idle.
// top level: witness sequencer around mrpt_mulmod; depends on mrpt_pkg, assert_macros.svh
`include "assert_macros.svh"
module miller_rabin_prime_test_core
    import mrpt_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0] s_tdata, // n
    output logic m_tvalid,
    input  logic m_tready,
    output logic [7:0] m_tdata                        // is_prime
);
    localparam int W = VALUE_WIDTH;
    localparam int SW = $clog2(W + 1);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_CLASS = 4'd1;
    localparam logic [3:0] ST_DECOMP = 4'd2;
    localparam logic [3:0] ST_BASE = 4'd3;
    localparam logic [3:0] ST_POW = 4'd4;
    localparam logic [3:0] ST_MACC = 4'd5;
    localparam logic [3:0] ST_MSQ = 4'd6;
    localparam logic [3:0] ST_CHK = 4'd7;
    localparam logic [3:0] ST_SQL = 4'd8;
    localparam logic [3:0] ST_MSQL = 4'd9;
    localparam logic [3:0] ST_DONE = 4'd10;

    logic [3:0]   state_reg, state_next;
    logic [W-1:0] n_reg, n_next, d_reg, d_next, e_reg, e_next;
    logic [W-1:0] acc_reg, acc_next, p_reg, p_next;
    logic [SW-1:0] s_reg, s_next, k_reg, k_next;
    logic [3:0]   widx_reg, widx_next;
    logic         res_reg, res_next;
    logic         ov_reg, ov_next, od_reg, od_next;
    logic         mm_start;
    logic [W-1:0] mm_x, mm_y, mm_r, nm1;
    logic [63:0]  n_ext;
    logic [W-1:0] wit;
    mm_stat_t     mm_stat;

    assign nm1 = n_reg - 1'b1;
    assign n_ext = 64'(n_reg);
    assign wit = W'(witness(widx_reg));

    mrpt_mulmod #(.VALUE_WIDTH(VALUE_WIDTH)) u_mulmod
    (
        .clk(clk), .rst_n(rst_n), .start(mm_start),
        .x(mm_x), .y(mm_y), .m(n_reg), .r(mm_r), .stat(mm_stat)
    );

    always_comb
    begin
        state_next = state_reg;
        n_next = n_reg;
        d_next = d_reg;
        e_next = e_reg;
        acc_next = acc_reg;
        p_next = p_reg;
        s_next = s_reg;
        k_next = k_reg;
        widx_next = widx_reg;
        res_next = res_reg;
        ov_next = ov_reg;
        od_next = od_reg;
        mm_start = 1'b0;
        mm_x = p_reg;
        mm_y = p_reg;
        if (ov_reg && m_tready)
            ov_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    n_next = s_tdata[W-1:0];
                    state_next = ST_CLASS;
                end
            end
            ST_CLASS:
            begin
                d_next = nm1;
                s_next = '0;
                if (n_reg < W'(2))
                begin
                    res_next = 1'b0;
                    state_next = ST_DONE;
                end
                else if (n_reg < W'(4))
                begin
                    res_next = 1'b1;
                    state_next = ST_DONE;
                end
                else if (n_ext == SKIP_COMPOSITE)
                begin
                    res_next = 1'b0;
                    state_next = ST_DONE;
                end
                else
                    state_next = ST_DECOMP;
            end
            ST_DECOMP:
            begin
                if (!d_reg[0] && d_reg != '0)
                begin
                    d_next = d_reg >> 1;
                    s_next = s_reg + 1'b1;
                end
                else
                begin
                    widx_next = '0;
                    state_next = ST_BASE;
                end
            end
            ST_BASE:
            begin
                if (widx_reg == 4'(WITNESS_COUNT) || wit >= n_reg)
                begin
                    res_next = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    acc_next = W'(1);
                    p_next = wit;
                    e_next = d_reg;
                    state_next = ST_POW;
                end
            end
            ST_POW:
            begin
                if (e_reg == '0)
                    state_next = ST_CHK;
                else if (e_reg[0])
                begin
                    mm_start = 1'b1;
                    mm_x = acc_reg;
                    state_next = ST_MACC;
                end
                else
                begin
                    mm_start = 1'b1;
                    state_next = ST_MSQ;
                end
            end
            ST_MACC:
            begin
                if (mm_stat.done)
                begin
                    acc_next = mm_r;
                    mm_start = 1'b1;
                    state_next = ST_MSQ;
                end
            end
            ST_MSQ:
            begin
                if (mm_stat.done)
                begin
                    p_next = mm_r;
                    e_next = e_reg >> 1;
                    state_next = ST_POW;
                end
            end
            ST_CHK:
            begin
                k_next = SW'(1);
                if (acc_reg == W'(1) || acc_reg == nm1)
                begin
                    widx_next = widx_reg + 1'b1;
                    state_next = ST_BASE;
                end
                else
                    state_next = ST_SQL;
            end
            ST_SQL:
            begin
                if (k_reg < s_reg)
                begin
                    mm_start = 1'b1;
                    mm_x = acc_reg;
                    mm_y = acc_reg;
                    state_next = ST_MSQL;
                end
                else
                begin
                    res_next = 1'b0;
                    state_next = ST_DONE;
                end
            end
            ST_MSQL:
            begin
                if (mm_stat.done)
                begin
                    acc_next = mm_r;
                    k_next = k_reg + 1'b1;
                    if (mm_r == nm1)
                    begin
                        widx_next = widx_reg + 1'b1;
                        state_next = ST_BASE;
                    end
                    else
                        state_next = ST_SQL;
                end
            end
            ST_DONE:
            begin
                if (!ov_reg || m_tready)
                begin
                    ov_next = 1'b1;
                    od_next = res_reg;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next;
        d_reg <= d_next;
        e_reg <= e_next;
        acc_reg <= acc_next;
        p_reg <= p_next;
        s_reg <= s_next;
        k_reg <= k_next;
        widx_reg <= widx_next;
        res_reg <= res_next;
        od_reg <= od_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = ov_reg;
    assign m_tdata = {7'd0, od_reg};

    `CHK_IMPL(a_start_idle_mul, clk, rst_n, mm_start, !mm_stat.busy)
    `CHK_IMPL(a_done_in_wait, clk, rst_n, mm_stat.done,
        state_reg == ST_MACC || state_reg == ST_MSQ || state_reg == ST_MSQL)
    `CHK_IMPL(a_witness_range, clk, rst_n, state_reg == ST_POW,
        widx_reg < 4'(WITNESS_COUNT))
    `CHK_NEXT(a_accept_class, clk, rst_n, s_tvalid && s_tready, state_reg == ST_CLASS)
endmodule

/* verif/tb.sv */
// regression bench for miller_rabin_prime_test_core: drives candidates, checks primality answers
// depends on mrpt_pkg and the core rtl; predictor is a deterministic 64-bit miller-rabin
`timescale 1ns / 1ps

class prime_scoreboard;
    bit answers[$];
    int mismatches;

    // (x * y) mod m, shift-and-add
    static function automatic logic [63:0] mul_mod(logic [63:0] x, logic [63:0] y,
                                                   logic [63:0] m);
        logic [64:0] r;
        r = 0;
        for (int i = 63; i >= 0; i--) begin
            r = r << 1;
            if (r >= {1'b0, m}) r = r - m;
            if (y[i]) begin
                r = r + x;
                if (r >= {1'b0, m}) r = r - m;
            end
        end
        return r[63:0];
    endfunction

    static function automatic bit witness_passes(logic [63:0] n, logic [63:0] a);
        logic [63:0] d, x, acc, p, e;
        int s;
        d = n - 1;
        s = 0;
        while (d[0] == 1'b0 && d != 0) begin
            d = d >> 1;
            s++;
        end
        acc = 1;
        p = a;
        e = d;
        while (e != 0) begin
            if (e[0]) acc = mul_mod(acc, p, n);
            p = mul_mod(p, p, n);
            e = e >> 1;
        end
        x = acc;
        if (x == 1 || x == n - 1) return 1;
        for (int k = 1; k < s; k++) begin
            x = mul_mod(x, x, n);
            if (x == n - 1) return 1;
        end
        return 0;
    endfunction

    static function automatic bit is_prime(logic [62:0] cand);
        logic [63:0] n;
        logic [63:0] bases[12];
        n = {1'b0, cand};
        bases = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37};
        if (n < 2) return 0;
        if (n < 4) return 1;
        if (n == 64'd3215031751) return 0;
        for (int i = 0; i < 12; i++) begin
            if (bases[i] >= n) break;
            if (!witness_passes(n, bases[i])) return 0;
        end
        return 1;
    endfunction

    function void note_candidate(logic [62:0] cand);
        answers = {answers, is_prime(cand)};
    endfunction

    function void check_answer(logic [7:0] tdata);
        bit want;
        if (answers.size() == 0) begin
            report("result with no candidate pending");
            return;
        end
        want = answers.pop_front();
        if (tdata[0] !== want)
            report($sformatf("is_prime got %0b want %0b", tdata[0], want));
    endfunction

    function void report(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endfunction
endclass

module tb;
    import mrpt_pkg::*;

    logic clk = 0;
    logic rst_n = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [63:0] s_tdata = 0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [7:0] m_tdata;

    prime_scoreboard sb = new();
    logic [62:0] candidates[$];
    bit calm = 0;
    bit hold_off = 0;
    bit sent_all = 0;

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    miller_rabin_prime_test_core DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    function automatic logic [62:0] rand63();
        return 63'({$urandom(), $urandom()});
    endfunction

    // mostly values of 32 bits or less so the run stays short; some of 40 bits and a few full-width ones
    function automatic logic [62:0] random_candidate();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) return rand63();
        if (pick < 4) return {23'd0, 8'($urandom_range(0, 255)), $urandom()} | 63'd1;
        if (pick < 8) return 63'($urandom_range(0, 2000));
        return {31'd0, $urandom()} | 63'd1;
    endfunction

    task automatic send_candidate(logic [62:0] cand);
        s_tvalid <= 1;
        s_tdata <= {1'b0, cand};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_candidate(cand);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    // receiver side
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (m_tvalid && m_tready) sb.check_answer(m_tdata);
            if (hold_off) m_tready <= 0;
            else if (!calm && $urandom_range(0, 4) == 0) begin
                m_tready <= 0;
                gap = $urandom_range(1, 9);
                repeat (gap - 1) @(posedge clk);
            end
            else m_tready <= 1;
        end
    end

    // long receiver stall while candidates keep coming
    initial
    begin
        @(posedge rst_n);
        repeat (40) @(posedge clk);
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
    end

    initial
    begin
        candidates = '{0, 1, 2, 3, 4, 5, 9, 37, 41, 561, 1105, 2047, 1373653,
                       25326001, 63'd3215031751, 63'd3215031753, 63'd4294967291,
                       63'd4294967296, 63'd2305843009213693951,
                       63'd9223372036854775807, 63'd9223372036854775783,
                       63'd3825123056546413051, 63'h5555555555555555,
                       63'h2aaaaaaaaaaaaaab};
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        foreach (candidates[i]) send_candidate(candidates[i]);
        for (int i = 0; i < 76; i++) begin
            if (i == 60) calm = 1;
            send_candidate(random_candidate());
        end
        s_tvalid <= 0;
        sent_all = 1;
        while (sb.answers.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (sb.mismatches == 0)
            $display("miller_rabin_prime_test_core regression: pass");
        else
            $display("miller_rabin_prime_test_core regression: fail");
        $finish;
    end

    // room for every candidate taking the full twelve-base worst case
    initial
    begin
        #1000000000;
        $display("miller_rabin_prime_test_core regression: fail");
        $finish;
    end
endmodule
